[hdl/sine_band_mixer_top_assert.svh]
`ifndef SINE_BAND_MIXER_TOP_ASSERT_SVH
`define SINE_BAND_MIXER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SBM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sine_band_mixer check failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SBM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sine_band_mixer check failed");

`endif

[hdl/sbm_pkg.sv]
package sbm_pkg;

    localparam int NUM_BANDS      = 4;
    localparam int MAX_ADDR_CH    = 4;
    localparam int SAMPLE_LIMIT   = 32000;
    localparam int RESULT_SHIFT   = 44;
    localparam int MAG_W          = 18;
    localparam int ACC_W          = 52;
    localparam int TERM_W         = 48;

    localparam logic [31:0] STEP_RESET [NUM_BANDS] =
        '{32'd62476000, 32'd12219000, 32'd555650000, 32'd46489000};
    localparam logic [15:0] VOL_RESET [NUM_BANDS] =
        '{16'd8192, 16'd20480, 16'd2048, 16'd12288};

    localparam logic [63:0] SINE_C1 = 64'd1686629713;
    localparam logic [63:0] SINE_C3 = 64'd693598668;
    localparam logic [63:0] SINE_C5 = 64'd85569306;
    localparam logic [63:0] SINE_C7 = 64'd5026995;
    localparam logic [63:0] SINE_C9 = 64'd172272;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_PHASE_STEP0 = 3'd0,
        REG_PHASE_STEP1 = 3'd1,
        REG_PHASE_STEP2 = 3'd2,
        REG_PHASE_STEP3 = 3'd3,
        REG_VOLUME0     = 3'd4,
        REG_VOLUME1     = 3'd5,
        REG_VOLUME2     = 3'd6,
        REG_VOLUME3     = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_MAG,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic       gain_wr;
        logic       clear_acc;
        logic       issue;
        logic [1:0] band;
        logic [1:0] ch;
        logic       scale;
        logic       mag;
        logic       load;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_status;

    function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                      input int unsigned tbits);
        logic [63:0]        half;
        logic [63:0]        quarter;
        logic [63:0]        k;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        p;
        logic [63:0]        s;
        logic [63:0]        v;
        logic signed [15:0] mag;
        half    = 64'd1 << (tbits - 1);
        quarter = 64'd1 << (tbits - 2);
        k       = 64'(idx) & (half - 64'd1);
        if (k > quarter) begin
            k = half - k;
        end
        x  = k << (32 - tbits);
        x2 = (x * x) >> 30;
        p  = SINE_C9;
        p  = SINE_C7 - ((x2 * p) >> 30);
        p  = SINE_C5 - ((x2 * p) >> 30);
        p  = SINE_C3 - ((x2 * p) >> 30);
        p  = SINE_C1 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        v  = (s + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        mag = $signed(v[15:0]);
        return ((64'(idx) & half) != 64'd0) ? -mag : mag;
    endfunction

endpackage

[hdl/sbm_ctrl.sv]
module sbm_ctrl
    import sbm_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_operation,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int NCH_EFF = (NUM_CHANNELS < MAX_ADDR_CH) ? NUM_CHANNELS : MAX_ADDR_CH;

    t_state     r_state, n_state;
    logic [1:0] r_band, n_band;
    logic [1:0] r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_band  <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_band     = r_band;
        n_ch       = r_ch;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.band = r_band;
        o_cmd.ch   = r_ch;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_band     = '0;
                n_ch       = '0;
                if (i_in_valid) begin
                    if (i_operation == OP_UPDATE) begin
                        o_cmd.gain_wr = 1'b1;
                    end else begin
                        o_cmd.clear_acc = 1'b1;
                        n_state         = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_ch == 2'(NCH_EFF - 1)) begin
                    n_ch = '0;
                    if (r_band == 2'(NUM_BANDS - 1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_band = r_band + 2'd1;
                    end
                end else begin
                    n_ch = r_ch + 2'd1;
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/sbm_datapath.sv]
module sbm_datapath
    import sbm_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int NUM_CHANNELS    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [1:0]         i_channel,
    input  logic signed [15:0] i_gain [NUM_BANDS],
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    output logic [31:0]        o_cfg_rdata,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample
);

    localparam int NCH_EFF    = (NUM_CHANNELS < MAX_ADDR_CH) ? NUM_CHANNELS : MAX_ADDR_CH;
    localparam int CH_W       = (NCH_EFF > 1) ? $clog2(NCH_EFF) : 1;
    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;

    logic [31:0]               r_step  [NUM_BANDS];
    logic [15:0]               r_vol   [NUM_BANDS];
    logic [PHASE_BITS-1:0]     r_phase [NUM_BANDS];
    logic signed [15:0]        r_gain  [NCH_EFF][NUM_BANDS];

    logic signed [15:0]        w_rom   [TABLE_SIZE];
    logic [PHASE_BITS-1:0]     w_step  [NUM_BANDS];
    logic                      w_mute  [NUM_BANDS];
    logic signed [16:0]        w_sum   [NUM_BANDS];
    logic [CH_W-1:0]           w_uch;
    logic [CH_W-1:0]           w_tch;
    logic                      w_ch_ok;
    logic [SINE_TABLE_BITS-1:0] w_idx;

    logic                      r_v1, r_v2, r_v3;
    logic signed [15:0]        r_sine;
    logic signed [15:0]        r_gain1;
    logic [15:0]               r_vol1, r_vol2;
    logic signed [31:0]        r_sg;
    logic signed [TERM_W-1:0]  r_sgv;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [63:0]        r_prod;
    logic                      r_neg;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_out_valid;
    logic signed [15:0]        r_sample;

    logic signed [63:0]        w_p;
    logic [63:0]               w_abs;
    logic [14:0]               w_clamp;
    logic signed [15:0]        w_out;
    t_reg_idx                  w_reg;

    for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
        assign w_rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
    end

    for (genvar gb = 0; gb < NUM_BANDS; gb++) begin : g_band
        assign w_step[gb] = PHASE_BITS'(r_step[gb]);
        assign w_mute[gb] = (w_step[gb] == '0);
    end

    assign w_reg = t_reg_idx'(i_cfg_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_step[b] <= STEP_RESET[b];
                r_vol[b]  <= VOL_RESET[b];
            end
        end else if (i_cfg_we) begin
            unique case (w_reg)
                REG_PHASE_STEP0: r_step[0] <= i_cfg_wdata;
                REG_PHASE_STEP1: r_step[1] <= i_cfg_wdata;
                REG_PHASE_STEP2: r_step[2] <= i_cfg_wdata;
                REG_PHASE_STEP3: r_step[3] <= i_cfg_wdata;
                REG_VOLUME0:     r_vol[0]  <= i_cfg_wdata[15:0];
                REG_VOLUME1:     r_vol[1]  <= i_cfg_wdata[15:0];
                REG_VOLUME2:     r_vol[2]  <= i_cfg_wdata[15:0];
                REG_VOLUME3:     r_vol[3]  <= i_cfg_wdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_PHASE_STEP0: o_cfg_rdata = r_step[0];
            REG_PHASE_STEP1: o_cfg_rdata = r_step[1];
            REG_PHASE_STEP2: o_cfg_rdata = r_step[2];
            REG_PHASE_STEP3: o_cfg_rdata = r_step[3];
            REG_VOLUME0:     o_cfg_rdata = {16'd0, r_vol[0]};
            REG_VOLUME1:     o_cfg_rdata = {16'd0, r_vol[1]};
            REG_VOLUME2:     o_cfg_rdata = {16'd0, r_vol[2]};
            REG_VOLUME3:     o_cfg_rdata = {16'd0, r_vol[3]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_phase[b] <= '0;
            end
        end else if (i_cmd.load) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_phase[b] <= r_phase[b] + w_step[b];
            end
        end
    end

    assign w_uch   = i_channel[CH_W-1:0];
    assign w_tch   = i_cmd.ch[CH_W-1:0];
    assign w_ch_ok = ({1'b0, i_channel} < 3'(NCH_EFF));

    always_comb begin
        for (int b = 0; b < NUM_BANDS; b++) begin
            w_sum[b] = 17'(r_gain[w_uch][b]) + 17'(i_gain[b]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH_EFF; c++) begin
                for (int b = 0; b < NUM_BANDS; b++) begin
                    r_gain[c][b] <= '0;
                end
            end
        end else if (i_cmd.gain_wr && w_ch_ok) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_gain[w_uch][b] <= w_sum[b][16:1];
            end
        end
    end

    assign w_idx = r_phase[i_cmd.band][PHASE_BITS-1 -: SINE_TABLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine  <= w_mute[i_cmd.band] ? 16'sd0 : w_rom[w_idx];
        r_gain1 <= r_gain[w_tch][i_cmd.band];
        r_vol1  <= r_vol[i_cmd.ch];
        r_sg    <= r_sine * r_gain1;
        r_vol2  <= r_vol1;
        r_sgv   <= r_sg * $signed({1'b0, r_vol2});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_sgv);
        end
    end

    assign w_p   = 64'(r_acc);
    assign w_abs = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_prod <= (w_p <<< 12) - (w_p <<< 10) - (w_p <<< 6) - (w_p <<< 3);
        end
        if (i_cmd.mag) begin
            r_neg <= r_prod[63];
            r_mag <= w_abs[RESULT_SHIFT +: MAG_W];
        end
    end

    assign w_clamp = (r_mag > MAG_W'(SAMPLE_LIMIT)) ? 15'(SAMPLE_LIMIT) : r_mag[14:0];
    assign w_out   = r_neg ? -$signed({1'b0, w_clamp}) : $signed({1'b0, w_clamp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= w_out;
        end
    end

    assign o_status.busy     = r_v1 | r_v2 | r_v3;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample          = r_sample;

endmodule

[hdl/sine_band_mixer_top.sv]
// Four-band additive sine mixer. A gain update transfer averages the new
// gains into the addressed channel and leaves the block ready for the next
// item. No new item is taken during a tick transfer: one shared
// sine-gain-volume multiply chain handles one band/channel term per cycle in
// RUN, followed by the pipeline drain in DRAIN and the SCALE, MAG and LOAD
// steps that scale, rectify and clamp the sum. LOAD holds for as long as the
// previous sample still waits in the output register. The sample sits in an
// output register, so a new item is accepted while it waits.
// Registers sit on the APB port at byte offsets 0x00-0x0C (band phase steps)
// and 0x10-0x1C (channel volumes).
`include "sine_band_mixer_top_assert.svh"

module sine_band_mixer_top
    import sbm_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int NUM_CHANNELS    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [1:0]         i_channel,
    input  logic signed [15:0] i_gain_band0,
    input  logic signed [15:0] i_gain_band1,
    input  logic signed [15:0] i_gain_band2,
    input  logic signed [15:0] i_gain_band3,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cmd               w_cmd;
    t_status            w_status;
    logic signed [15:0] w_gain [NUM_BANDS];
    logic               w_cfg_we;

    assign pready    = 1'b1;
    assign w_cfg_we  = psel & penable & pwrite & pready;
    assign w_gain[0] = i_gain_band0;
    assign w_gain[1] = i_gain_band1;
    assign w_gain[2] = i_gain_band2;
    assign w_gain[3] = i_gain_band3;

    sbm_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sbm_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .NUM_CHANNELS    (NUM_CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_channel   (i_channel),
        .i_gain      (w_gain),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_addr  (paddr[4:2]),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample)
    );

    `SBM_ASSERT_NOW(a_ready_pipe_empty, o_in_ready, !w_status.busy)
    `SBM_ASSERT_NOW(a_load_has_space, w_cmd.load, w_status.out_free)
    `SBM_ASSERT_NXT(a_load_shows_sample, w_cmd.load, o_out_valid)
    `SBM_ASSERT_NOW(a_sample_in_range, o_out_valid, (o_sample <= 16'sd32000) && (o_sample >= -16'sd32000))

endmodule

[tb/sv/tb_top.sv]
module tb_top
    import sbm_pkg::*;
();

    class mix_predictor;
        localparam int TABLE_LEN = 1024;
        localparam int HALF_TURN = 512;
        localparam int QUARTER_TURN = 256;
        localparam longint TONE_SCALE = 3000;
        localparam longint SAMPLE_LIMIT = 32000;

        logic [31:0]        step [4];
        logic [15:0]        vol [4];
        logic [31:0]        phase [4];
        logic signed [15:0] gain [4][4];
        logic signed [15:0] sine_lut [TABLE_LEN];
        logic signed [15:0] expected_samples [$];
        int                 errors;

        function new();
            for (int i = 0; i < TABLE_LEN; i++) begin
                sine_lut[i] = sine_of(i);
            end
            step[0] = 32'd62476000;
            step[1] = 32'd12219000;
            step[2] = 32'd555650000;
            step[3] = 32'd46489000;
            vol[0]  = 16'd8192;
            vol[1]  = 16'd20480;
            vol[2]  = 16'd2048;
            vol[3]  = 16'd12288;
            for (int b = 0; b < 4; b++) begin
                phase[b] = '0;
                for (int c = 0; c < 4; c++) begin
                    gain[c][b] = '0;
                end
            end
            errors = 0;
        endfunction

        // quarter-wave fold, odd degree 9 polynomial in Q30, rounded to Q15
        function logic signed [15:0] sine_of(int unsigned i);
            longint unsigned k;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned p;
            longint unsigned s;
            longint unsigned v;
            k = i & (HALF_TURN - 1);
            if (k > QUARTER_TURN) begin
                k = HALF_TURN - k;
            end
            x  = k << 22;
            x2 = (x * x) >> 30;
            p  = 64'd172272;
            p  = 64'd5026995 - ((x2 * p) >> 30);
            p  = 64'd85569306 - ((x2 * p) >> 30);
            p  = 64'd693598668 - ((x2 * p) >> 30);
            p  = 64'd1686629713 - ((x2 * p) >> 30);
            s  = (x * p) >> 30;
            v  = (s + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            if ((i & HALF_TURN) != 0) begin
                return -$signed(v[15:0]);
            end else begin
                return $signed(v[15:0]);
            end
        endfunction

        function void set_reg(t_reg_idx r, logic [31:0] v);
            int idx;
            idx = int'(r);
            if (r < REG_VOLUME0) begin
                step[idx] = v;
            end else begin
                vol[idx - int'(REG_VOLUME0)] = v[15:0];
            end
        endfunction

        function void take_item(t_op op, logic [1:0] ch, logic [3:0][15:0] g);
            longint acc;
            longint mag;
            int     sum;
            logic signed [15:0] s;
            if (op == OP_UPDATE) begin
                for (int b = 0; b < 4; b++) begin
                    sum = int'(gain[ch][b]) + int'($signed(g[b]));
                    gain[ch][b] = 16'(sum >>> 1);
                end
                return;
            end
            acc = 0;
            for (int b = 0; b < 4; b++) begin
                if (step[b] != '0) begin
                    s = sine_lut[phase[b][31:22]];
                    for (int c = 0; c < 4; c++) begin
                        acc += longint'(s) * longint'(gain[c][b]) * longint'(vol[c])
                               * TONE_SCALE;
                    end
                end
            end
            if (acc < 0) begin
                mag = -((-acc) >>> 44);
            end else begin
                mag = acc >>> 44;
            end
            if (mag > SAMPLE_LIMIT) begin
                mag = SAMPLE_LIMIT;
            end else if (mag < -SAMPLE_LIMIT) begin
                mag = -SAMPLE_LIMIT;
            end
            expected_samples.push_back(16'(mag));
            for (int b = 0; b < 4; b++) begin
                phase[b] = phase[b] + step[b];
            end
        endfunction

        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                if (errors < 10) begin
                    $display("sample %0d with none expected", got);
                end
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want) begin
                if (errors < 10) begin
                    $display("sample mismatch: expected %0d, got %0d", want, got);
                end
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    localparam int          LIMIT           = 400000;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          PHASES          = 6;
    localparam int          ITEMS_PER_PHASE = 67;
    localparam logic [15:0] GAIN_MAX        = 16'h7FFF;
    localparam logic [15:0] GAIN_MIN        = 16'h8000;
    localparam logic [31:0] STEP_MAX        = 32'hFFFF_FFFF;
    localparam logic [15:0] VOL_MAX         = 16'hFFFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_operation = 1'b0;
    logic [1:0]         i_channel = '0;
    logic signed [15:0] i_gain_band0 = '0;
    logic signed [15:0] i_gain_band1 = '0;
    logic signed [15:0] i_gain_band2 = '0;
    logic signed [15:0] i_gain_band3 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic signed [15:0] o_sample;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    mix_predictor mixer_model;
    int           cycles = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;

    sine_band_mixer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_channel    (i_channel),
        .i_gain_band0 (i_gain_band0),
        .i_gain_band1 (i_gain_band1),
        .i_gain_band2 (i_gain_band2),
        .i_gain_band3 (i_gain_band3),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample     (o_sample),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            mixer_model.check_sample(o_sample);
        end
    end

    task automatic send_item(t_op op, logic [1:0] ch, logic [3:0][15:0] g);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_channel    <= ch;
        i_gain_band0 <= g[0];
        i_gain_band1 <= g[1];
        i_gain_band2 <= g[2];
        i_gain_band3 <= g[3];
        do @(posedge i_clk); while (!o_in_ready);
        mixer_model.take_item(op, ch, g);
    endtask

    task automatic apb_write(t_reg_idx r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mixer_model.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_bank(logic [3:0][31:0] steps, logic [3:0][15:0] vols);
        for (int b = 0; b < 4; b++) begin
            apb_write(t_reg_idx'(b), steps[b]);
            apb_write(t_reg_idx'(int'(REG_VOLUME0) + b), {16'h0000, vols[b]});
        end
    endtask

    // hold off until every expected sample has come, then let the block settle
    task automatic wait_idle();
        int n = 0;
        i_in_valid <= 1'b0;
        while (mixer_model.pending() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [3:0][15:0] rand_gains();
        logic [3:0][15:0] g;
        for (int b = 0; b < 4; b++) begin
            case ($urandom_range(7))
                0: g[b] = GAIN_MAX;
                1: g[b] = GAIN_MIN;
                default: g[b] = 16'($urandom);
            endcase
        end
        return g;
    endfunction

    initial begin
        logic [3:0][31:0] steps;
        logic [3:0][15:0] vols;
        int               k;
        t_op              op;

        mixer_model = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_TICK, 2'd0, '0);
        send_item(OP_UPDATE, 2'd0, {4{GAIN_MAX}});
        send_item(OP_UPDATE, 2'd1, {4{GAIN_MIN}});
        send_item(OP_UPDATE, 2'd2, {16'hFFFF, 16'h0000, GAIN_MIN, GAIN_MAX});
        send_item(OP_UPDATE, 2'd3, {16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001});
        repeat (3) send_item(OP_TICK, 2'd0, '0);

        wait_idle();
        write_bank({4{STEP_MAX}}, {4{VOL_MAX}});
        for (int c = 0; c < 4; c++) begin
            send_item(OP_UPDATE, 2'(c), {4{GAIN_MAX}});
        end
        repeat (2) send_item(OP_TICK, 2'd0, '0);
        for (int c = 0; c < 4; c++) begin
            send_item(OP_UPDATE, 2'(c), {4{GAIN_MIN}});
        end
        send_item(OP_TICK, 2'd0, '0);

        wait_idle();
        write_bank('0, {4{VOL_MAX}});
        repeat (2) send_item(OP_TICK, 2'd0, '0);

        k = 0;
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            for (int b = 0; b < 4; b++) begin
                case (p)
                    1: begin
                        steps[b] = $urandom_range(32'h0400_0000);
                        vols[b]  = 16'($urandom);
                    end
                    2: begin
                        steps[b] = $urandom_range(1) ? STEP_MAX : '0;
                        vols[b]  = $urandom_range(1) ? VOL_MAX : '0;
                    end
                    3: begin
                        steps[b] = {8'($urandom_range(255)), 24'h000000};
                        vols[b]  = 16'($urandom_range(4095));
                    end
                    default: begin
                        steps[b] = $urandom;
                        vols[b]  = 16'($urandom);
                    end
                endcase
            end
            write_bank(steps, vols);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (k < 133) begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 50;
                end else if (k < 266) begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 21;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                op = ($urandom_range(99) < 55) ? OP_TICK : OP_UPDATE;
                send_item(op, 2'($urandom_range(3)), rand_gains());
                k++;
            end
        end

        wait_idle();
        if (mixer_model.errors == 0 && mixer_model.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/sbm_pkg.sv
hdl/sbm_ctrl.sv
hdl/sbm_datapath.sv
hdl/sine_band_mixer_top.sv
tb/sv/tb_top.sv
